// ----- hdl/two_section_image_loader_macros.svh -----
// ----------------------------------------------------------------------------
// two_section_image_loader_macros
// assertion macros shared by the loader rtl
// ----------------------------------------------------------------------------
`ifndef TWO_SECTION_IMAGE_LOADER_MACROS_SVH
`define TWO_SECTION_IMAGE_LOADER_MACROS_SVH

`ifndef ASSERT_OFF

// property checked every clock outside reset
`define TSIL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("loader assertion failed");

// property checked every clock, reset included
`define TSIL_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("loader assertion failed");

`else

`define TSIL_ASSERT(label, prop)
`define TSIL_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- hdl/tsil_pkg.sv -----
// ----------------------------------------------------------------------------
// tsil_pkg
// types and constants of the two-section image loader
// ----------------------------------------------------------------------------
`default_nettype none

package tsil_pkg;

    localparam int BYTE_W      = 8;
    localparam int TADDR_W     = 32;
    localparam int LEN_W       = 32;
    localparam int QUEUE_DEPTH = 2;

    // result kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_JUMP  = 1'b1;

    // sections
    localparam logic SEC_INSTR = 1'b0;
    localparam logic SEC_DATA  = 1'b1;

    // one classified byte, handed from the parser to the result sequencer
    typedef struct packed {
        logic                 wr;       // memory write of data
        logic                 jmp;      // jump follows (after the write, if any)
        logic                 section;
        logic [TADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]    data;
    } op_t;

endpackage

`default_nettype wire

// ----- hdl/tsil_rx_if.sv -----
// ----------------------------------------------------------------------------
// tsil_rx_if
// received byte channel
// ----------------------------------------------------------------------------
`default_nettype none

interface tsil_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/tsil_res_if.sv -----
// ----------------------------------------------------------------------------
// tsil_res_if
// result channel: memory writes and the final jump
// ----------------------------------------------------------------------------
`default_nettype none

interface tsil_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        section;
    logic [31:0] target_address;
    logic [7:0]  write_data;
    logic        last_of_run;

    modport source (output valid, output kind, output section, output target_address,
                    output write_data, output last_of_run, input ready);
    modport sink   (input valid, input kind, input section, input target_address,
                    input write_data, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hdl/tsil_queue.sv -----
// ----------------------------------------------------------------------------
// tsil_queue
// short fifo of classified bytes between parser and result sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module tsil_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  tsil_pkg::op_t       push_op,
    output logic                full,
    input  wire logic           pop,
    output tsil_pkg::op_t       pop_op,
    output logic                not_empty
);
    import tsil_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

`include "two_section_image_loader_macros.svh"

    `TSIL_ASSERT(a_no_overflow, push |-> (!full || pop))
    `TSIL_ASSERT(a_no_underflow, pop |-> not_empty)
    `TSIL_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ----- hdl/tsil_front.sv -----
// ----------------------------------------------------------------------------
// tsil_front
// byte parser: assembles headers, tracks sections, classifies content bytes
// ----------------------------------------------------------------------------
`default_nettype none

module tsil_front #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    tsil_rx_if.sink                         rx,
    input  wire logic                       q_full,
    output logic                            push,
    output tsil_pkg::op_t                   push_op,
    output logic [tsil_pkg::TADDR_W-1:0]    entry_address
);
    import tsil_pkg::*;

    localparam logic [2:0] PH_IADDR = 3'd0;
    localparam logic [2:0] PH_ILEN  = 3'd1;
    localparam logic [2:0] PH_IDATA = 3'd2;
    localparam logic [2:0] PH_DADDR = 3'd3;
    localparam logic [2:0] PH_DLEN  = 3'd4;
    localparam logic [2:0] PH_DDATA = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    logic [2:0]            phase_reg,  phase_next;
    logic [23:0]           shift_reg,  shift_next;
    logic [1:0]            idx_reg,    idx_next;
    logic [ADDR_WIDTH-1:0] wptr_reg,   wptr_next;
    logic [LEN_W-1:0]      remain_reg, remain_next;
    logic [ADDR_WIDTH-1:0] entry_reg,  entry_next;

    logic             accept;
    logic             is_header;
    logic             hdr_done;
    logic [LEN_W-1:0] word;
    logic             rem_last;
    logic             jmp_push;

    assign rx.ready      = !q_full;
    assign accept        = rx.valid && rx.ready;
    assign hdr_done      = (idx_reg == 2'd3);
    assign word          = {rx.rx_byte, shift_reg};
    assign rem_last      = (remain_reg == LEN_W'(1));
    assign entry_address = TADDR_W'(entry_reg);
    assign is_header     = (phase_reg == PH_IADDR) || (phase_reg == PH_ILEN) ||
                           (phase_reg == PH_DADDR) || (phase_reg == PH_DLEN);
    assign jmp_push      = push && push_op.jmp;

    always_comb
    begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        idx_next        = idx_reg;
        wptr_next       = wptr_reg;
        remain_next     = remain_reg;
        entry_next      = entry_reg;
        push            = 1'b0;
        push_op.wr      = 1'b0;
        push_op.jmp     = 1'b0;
        push_op.section = SEC_INSTR;
        push_op.addr    = TADDR_W'(wptr_reg);
        push_op.data    = rx.rx_byte;

        if (accept && is_header)
        begin
            // little-endian header word, four beats
            if (hdr_done)
            begin
                idx_next = 2'd0;
            end
            else
            begin
                shift_next[{idx_reg, 3'b000} +: 8] = rx.rx_byte;
                idx_next = idx_reg + 2'd1;
            end
        end

        if (accept)
        begin
            case (phase_reg)
                PH_IADDR:
                begin
                    if (hdr_done)
                    begin
                        entry_next = word[ADDR_WIDTH-1:0];
                        wptr_next  = word[ADDR_WIDTH-1:0];
                        phase_next = PH_ILEN;
                    end
                end
                PH_ILEN:
                begin
                    if (hdr_done)
                    begin
                        remain_next = word;
                        phase_next  = (word == '0) ? PH_DADDR : PH_IDATA;
                    end
                end
                PH_IDATA:
                begin
                    push        = 1'b1;
                    push_op.wr  = 1'b1;
                    wptr_next   = wptr_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                    if (rem_last)
                    begin
                        phase_next = PH_DADDR;
                    end
                end
                PH_DADDR:
                begin
                    if (hdr_done)
                    begin
                        wptr_next  = word[ADDR_WIDTH-1:0];
                        phase_next = PH_DLEN;
                    end
                end
                PH_DLEN:
                begin
                    if (hdr_done)
                    begin
                        remain_next = word;
                        if (word == '0)
                        begin
                            // empty data section: jump straight away
                            push        = 1'b1;
                            push_op.jmp = 1'b1;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_DDATA;
                        end
                    end
                end
                PH_DDATA:
                begin
                    push            = 1'b1;
                    push_op.wr      = 1'b1;
                    push_op.jmp     = rem_last;
                    push_op.section = SEC_DATA;
                    wptr_next       = wptr_reg + 1'b1;
                    remain_next     = remain_reg - 1'b1;
                    if (rem_last)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    // done: bytes are swallowed until reset
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IADDR;
            shift_reg  <= '0;
            idx_reg    <= '0;
            wptr_reg   <= '0;
            remain_reg <= '0;
            entry_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            idx_reg    <= idx_next;
            wptr_reg   <= wptr_next;
            remain_reg <= remain_next;
            entry_reg  <= entry_next;
        end
    end

`include "two_section_image_loader_macros.svh"

    `TSIL_ASSERT(a_jump_only_from_data, jmp_push |-> (phase_reg == PH_DLEN || phase_reg == PH_DDATA))
    `TSIL_ASSERT(a_done_is_final, (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
    `TSIL_ASSERT(a_push_has_room, push |-> !q_full)

endmodule

`default_nettype wire

// ----- hdl/tsil_back.sv -----
// ----------------------------------------------------------------------------
// tsil_back
// result sequencer: turns queued bytes into write and jump results
// ----------------------------------------------------------------------------
`default_nettype none

module tsil_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_not_empty,
    input  tsil_pkg::op_t                   q_op,
    output logic                            q_pop,
    input  wire logic [tsil_pkg::TADDR_W-1:0] entry_address,
    tsil_res_if.source                      res
);
    import tsil_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic                jmp_pending_reg, jmp_pending_next;
    logic                kind_reg, kind_next;
    logic                section_reg, section_next;
    logic [TADDR_W-1:0]  addr_reg, addr_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic                last_reg, last_next;
    logic                load;
    logic                out_data_write;
    logic                out_jump;

    // output register free or being drained this cycle
    assign load = !out_valid_reg || res.ready;

    assign out_data_write = out_valid_reg && (kind_reg == KIND_WRITE) && (section_reg == SEC_DATA);
    assign out_jump       = out_valid_reg && (kind_reg == KIND_JUMP);

    assign res.valid          = out_valid_reg;
    assign res.kind           = kind_reg;
    assign res.section        = section_reg;
    assign res.target_address = addr_reg;
    assign res.write_data     = data_reg;
    assign res.last_of_run    = last_reg;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        jmp_pending_next = jmp_pending_reg;
        kind_next        = kind_reg;
        section_next     = section_reg;
        addr_next        = addr_reg;
        data_next        = data_reg;
        last_next        = last_reg;
        q_pop            = 1'b0;

        if (load)
        begin
            if (jmp_pending_reg)
            begin
                // second beat of the final data byte
                out_valid_next   = 1'b1;
                jmp_pending_next = 1'b0;
                kind_next        = KIND_JUMP;
                section_next     = SEC_INSTR;
                addr_next        = entry_address;
                data_next        = '0;
                last_next        = 1'b1;
            end
            else if (q_not_empty)
            begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                if (q_op.wr)
                begin
                    kind_next        = KIND_WRITE;
                    section_next     = q_op.section;
                    addr_next        = q_op.addr;
                    data_next        = q_op.data;
                    last_next        = !q_op.jmp;
                    jmp_pending_next = q_op.jmp;
                end
                else
                begin
                    kind_next    = KIND_JUMP;
                    section_next = SEC_INSTR;
                    addr_next    = entry_address;
                    data_next    = '0;
                    last_next    = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            jmp_pending_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            jmp_pending_reg <= jmp_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        section_reg <= section_next;
        addr_reg    <= addr_next;
        data_reg    <= data_next;
        last_reg    <= last_next;
    end

`include "two_section_image_loader_macros.svh"

    `TSIL_ASSERT(a_pending_needs_write, jmp_pending_reg |-> (out_data_write && !last_reg))
    `TSIL_ASSERT(a_jump_is_last, out_jump |-> last_reg)
    `TSIL_ASSERT(a_no_pop_while_pending, jmp_pending_reg |-> !q_pop)

endmodule

`default_nettype wire

// ----- hdl/two_section_image_loader.sv -----
// ----------------------------------------------------------------------------
// two_section_image_loader
// parses a serial program image (instruction then data section) into
// byte memory writes and a final jump to the instruction start address
// ----------------------------------------------------------------------------
// channel  dir  payload                                             beat per
// rx       in   rx_byte                                             received byte
// res      out  kind, section, target_address, write_data,          result
//               last_of_run
//
// one byte is accepted every cycle while the two-entry queue has room
// a result passes through the queue and then the result register after its byte is accepted
// the last data byte yields two beats (write, then jump) in the result
// register; every other byte yields at most one
// reset clears the parser and the queue; no clearing pass is needed
// rx and res stall independently through the queue and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module two_section_image_loader #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tsil_rx_if.sink     rx,
    tsil_res_if.source  res
);
    import tsil_pkg::*;

    logic               push;
    op_t                push_op;
    logic               q_full;
    logic               q_pop;
    op_t                q_op;
    logic               q_not_empty;
    logic [TADDR_W-1:0] entry_address;

    tsil_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx),
        .q_full        (q_full),
        .push          (push),
        .push_op       (push_op),
        .entry_address (entry_address)
    );

    tsil_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (q_pop),
        .pop_op    (q_op),
        .not_empty (q_not_empty)
    );

    tsil_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_op          (q_op),
        .q_pop         (q_pop),
        .entry_address (entry_address),
        .res           (res)
    );

endmodule

`default_nettype wire
